// ===== rtl/sctc_pkg.sv =====
// Shared types, constants and the character ROM of the scan code translator.
package sctc_pkg;

    localparam int KEY_TABLE_DEPTH = 128;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = 1;
    localparam int QCNT_W          = 2;

    localparam logic [7:0] PREFIX_CODE = 8'd224;
    localparam logic [7:0] NULL_CODE   = 8'd0;
    localparam logic [7:0] MARKER      = 8'd0;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] FKEY_FIRST  = 8'd59;
    localparam logic [7:0] FKEY_LAST   = 8'd68;
    localparam logic [7:0] FKEY_BIAS   = 8'd57;

    typedef struct packed {
        logic       special;
        logic [7:0] value;
    } entry_t;

    typedef struct packed {
        logic   valid;
        entry_t entry;
    } push_t;

    function automatic entry_t mk_special(input logic [7:0] code);
        entry_t e;
        e.special = 1'b1;
        e.value   = code;
        return e;
    endfunction

    function automatic entry_t mk_char(input logic [7:0] ch);
        entry_t e;
        e.special = 1'b0;
        e.value   = ch;
        return e;
    endfunction

    // Character ROM, entries past the listed ones read as zero
    function automatic logic [7:0] rom_lookup(input logic [6:0] idx);
        logic [7:0] ch;
        case (idx)
            7'd1:  ch = 8'd27;
            7'd2:  ch = 8'd49;
            7'd3:  ch = 8'd50;
            7'd4:  ch = 8'd51;
            7'd5:  ch = 8'd52;
            7'd6:  ch = 8'd53;
            7'd7:  ch = 8'd54;
            7'd8:  ch = 8'd55;
            7'd9:  ch = 8'd56;
            7'd10: ch = 8'd57;
            7'd11: ch = 8'd48;
            7'd12: ch = 8'd39;
            7'd14: ch = 8'd8;
            7'd15: ch = 8'd9;
            7'd16: ch = 8'd113;
            7'd17: ch = 8'd119;
            7'd18: ch = 8'd101;
            7'd19: ch = 8'd114;
            7'd20: ch = 8'd116;
            7'd21: ch = 8'd121;
            7'd22: ch = 8'd117;
            7'd23: ch = 8'd105;
            7'd24: ch = 8'd111;
            7'd25: ch = 8'd112;
            7'd28: ch = 8'd10;
            7'd30: ch = 8'd97;
            7'd31: ch = 8'd115;
            7'd32: ch = 8'd100;
            7'd33: ch = 8'd102;
            7'd34: ch = 8'd103;
            7'd35: ch = 8'd104;
            7'd36: ch = 8'd106;
            7'd37: ch = 8'd107;
            7'd38: ch = 8'd108;
            7'd39: ch = 8'd164;
            7'd40, 7'd41, 7'd42, 7'd43: ch = 8'd48;
            7'd44: ch = 8'd122;
            7'd45: ch = 8'd120;
            7'd46: ch = 8'd99;
            7'd47: ch = 8'd118;
            7'd48: ch = 8'd98;
            7'd49: ch = 8'd110;
            7'd50, 7'd51, 7'd52, 7'd53, 7'd54, 7'd55, 7'd56: ch = 8'd109;
            7'd57: ch = 8'd32;
            7'd59: ch = 8'd109;
            default: ch = 8'd0;
        endcase
        if (32'(idx) >= KEY_TABLE_DEPTH) begin
            ch = 8'd0;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/sctc_front.sv =====
// Front end: accepts scan code beats, tracks modifier flags and classifies each code.
module sctc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_scan_code,
    input  logic            q_full,
    output sctc_pkg::push_t push
);

    logic            shift_reg, shift_next;
    logic            caps_reg, caps_next;
    logic            altgr_reg, altgr_next;
    logic            ext_reg, ext_next;
    logic            accept;
    logic            shifted;
    logic            produce;
    logic [7:0]      c;
    logic [7:0]      rom_ch;
    sctc_pkg::entry_t ent;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign c       = s_scan_code;
    assign shifted = shift_reg || caps_reg;

    always_comb begin
        rom_ch = sctc_pkg::rom_lookup(c[6:0]);
        if (shifted && rom_ch >= 8'd97 && rom_ch <= 8'd122) begin
            rom_ch = rom_ch - sctc_pkg::CASE_OFFSET;
        end
    end

    always_comb begin
        produce    = 1'b0;
        ent        = sctc_pkg::mk_char(8'd0);
        shift_next = shift_reg;
        caps_next  = caps_reg;
        altgr_next = altgr_reg;
        ext_next   = ext_reg;
        if (c == sctc_pkg::NULL_CODE) begin
            produce = 1'b0;
        end else if (ext_reg) begin
            ext_next = 1'b0;
            unique case (c)
                8'd82:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd15); end
                8'd83:  begin produce = 1'b1; ent = sctc_pkg::mk_char(8'd127); end
                8'd29:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd24); end
                8'd157: begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd25); end
                8'd56:  altgr_next = 1'b1;
                8'd184: altgr_next = 1'b0;
                8'd72:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd20); end
                8'd80:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd21); end
                8'd75:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd23); end
                8'd77:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd22); end
                8'd71:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd30); end
                8'd79:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd31); end
                8'd73:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd32); end
                8'd81:  begin produce = 1'b1; ent = sctc_pkg::mk_special(8'd33); end
                default: produce = 1'b0;
            endcase
        end else if (c == sctc_pkg::PREFIX_CODE) begin
            ext_next = 1'b1;
        end else if (c >= sctc_pkg::FKEY_FIRST && c <= sctc_pkg::FKEY_LAST) begin
            produce = 1'b1;
            ent     = sctc_pkg::mk_special(c - sctc_pkg::FKEY_BIAS);
        end else begin
            produce = 1'b1;
            unique case (c) inside
                8'd1:   ent = sctc_pkg::mk_char(8'd1);
                8'd87:  ent = sctc_pkg::mk_special(8'd12);
                8'd88:  ent = sctc_pkg::mk_special(8'd13);
                8'd14:  ent = sctc_pkg::mk_char(8'd8);
                8'd15:  ent = sctc_pkg::mk_char(8'd9);
                8'd28:  ent = sctc_pkg::mk_char(8'd10);
                8'd29:  ent = sctc_pkg::mk_special(8'd24);
                8'd157: ent = sctc_pkg::mk_special(8'd25);
                8'd56:  ent = sctc_pkg::mk_special(8'd26);
                8'd184: ent = sctc_pkg::mk_special(8'd27);
                8'd42, 8'd54: begin produce = 1'b0; shift_next = 1'b1; end
                8'd170, 8'd182: begin produce = 1'b0; shift_next = 1'b0; end
                8'd58:  begin produce = 1'b0; caps_next = !caps_reg; end
                8'd39:  ent = sctc_pkg::mk_char(shifted ? 8'd165 : 8'd164);
                8'd16:  ent = sctc_pkg::mk_char(altgr_reg ? 8'd64 :
                                                 (shifted ? 8'd81 : 8'd113));
                8'd86:  ent = sctc_pkg::mk_char(shifted ? 8'd62 : 8'd60);
                8'd53:  ent = sctc_pkg::mk_char(shifted ? 8'd95 : 8'd45);
                8'd52:  ent = sctc_pkg::mk_char(shifted ? 8'd58 : 8'd46);
                8'd51:  ent = sctc_pkg::mk_char(shifted ? 8'd59 : 8'd44);
                8'd40:  ent = sctc_pkg::mk_char(altgr_reg ? 8'd94 :
                                                 (shifted ? 8'd91 : 8'd123));
                8'd43:  ent = sctc_pkg::mk_char(altgr_reg ? 8'd96 :
                                                 (shifted ? 8'd93 : 8'd125));
                8'd27:  ent = sctc_pkg::mk_char(altgr_reg ? 8'd126 :
                                                 (shifted ? 8'd42 : 8'd43));
                8'd26:  ent = sctc_pkg::mk_char(shifted ? 8'd249 : 8'd239);
                8'd41:  ent = sctc_pkg::mk_char(altgr_reg ? 8'd170 :
                                                 (shifted ? 8'd167 : 8'd124));
                8'd13:  ent = sctc_pkg::mk_char(shifted ? 8'd173 : 8'd168);
                8'd12:  ent = sctc_pkg::mk_char(altgr_reg ? 8'd92 :
                                                 (shifted ? 8'd63 : 8'd39));
                8'd2:   ent = sctc_pkg::mk_char(shifted ? 8'd33 : 8'd49);
                8'd3:   ent = sctc_pkg::mk_char(shifted ? 8'd34 : 8'd50);
                8'd4:   ent = sctc_pkg::mk_char(shifted ? 8'd35 : 8'd51);
                8'd5:   ent = sctc_pkg::mk_char(shifted ? 8'd36 : 8'd52);
                8'd6:   ent = sctc_pkg::mk_char(shifted ? 8'd37 : 8'd53);
                8'd7:   ent = sctc_pkg::mk_char(shifted ? 8'd38 : 8'd54);
                8'd8:   ent = sctc_pkg::mk_char(shifted ? 8'd47 : 8'd55);
                8'd9:   ent = sctc_pkg::mk_char(shifted ? 8'd40 : 8'd56);
                8'd10:  ent = sctc_pkg::mk_char(shifted ? 8'd41 : 8'd57);
                8'd11:  ent = sctc_pkg::mk_char(shifted ? 8'd61 : 8'd48);
                default: begin
                    produce = !c[7];
                    ent     = sctc_pkg::mk_char(rom_ch);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
            altgr_reg <= 1'b0;
            ext_reg   <= 1'b0;
        end else if (accept) begin
            shift_reg <= shift_next;
            caps_reg  <= caps_next;
            altgr_reg <= altgr_next;
            ext_reg   <= ext_next;
        end
    end

    assign push.valid = accept && produce;
    assign push.entry = ent;

endmodule

// ===== rtl/sctc_queue.sv =====
// Two-entry queue between the classifier and the output sequencer.
module sctc_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  sctc_pkg::push_t  push,
    output logic             full,
    output logic             q_valid,
    output sctc_pkg::entry_t q_entry,
    input  logic             pop
);

    sctc_pkg::entry_t                  mem_reg [sctc_pkg::QUEUE_DEPTH];
    logic [sctc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sctc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sctc_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full    = count_reg == sctc_pkg::QCNT_W'(sctc_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/sctc_back.sv =====
// Output sequencer: turns queued entries into one or two result beats.
module sctc_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  sctc_pkg::entry_t q_entry,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_char,
    output logic             m_last_of_run
);

    logic       m_valid_reg;
    logic [7:0] out_char_reg;
    logic       last_reg;
    logic       tail_pending_reg;
    logic [7:0] tail_code_reg;
    logic       load;

    assign load = !m_valid_reg || m_ready;
    assign pop  = load && !tail_pending_reg && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg      <= 1'b0;
            tail_pending_reg <= 1'b0;
        end else if (load) begin
            if (tail_pending_reg) begin
                m_valid_reg      <= 1'b1;
                tail_pending_reg <= 1'b0;
            end else begin
                m_valid_reg      <= q_valid;
                tail_pending_reg <= q_valid && q_entry.special;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (tail_pending_reg) begin
                out_char_reg <= tail_code_reg;
                last_reg     <= 1'b1;
            end else if (q_entry.special) begin
                out_char_reg  <= sctc_pkg::MARKER;
                last_reg      <= 1'b0;
                tail_code_reg <= q_entry.value;
            end else begin
                out_char_reg <= q_entry.value;
                last_reg     <= 1'b1;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_last_of_run = last_reg;

endmodule

// ===== rtl/scancode_to_char_translator.sv =====
// Top level: set-1 scan code to Spanish-layout character translator.
// A scan code's entry is written into the queue, then registered in the output sequencer as its first beat.
// Throughput: one scan code per cycle while the two-entry queue has room; the output
// sequencer sends one beat per cycle while m_ready is high; a special key gives a marker beat, then its code.
// Reset (aresetn low, synchronous): modifier flags, prefix flag, queue and output valid clear.
module scancode_to_char_translator (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_scan_code,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_run
);

    sctc_pkg::push_t  push;
    sctc_pkg::entry_t q_entry;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;

    sctc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_scan_code (s_scan_code),
        .q_full      (q_full),
        .push        (push)
    );

    sctc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (q_pop)
    );

    sctc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_entry       (q_entry),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== rtl/sctc_checker.sv =====
// Port-level assertions for the translator, bound to the top level.
module sctc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_last_of_run
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_out_char == 8'd0)
        else $error("non-final beat is not a zero marker");

    a_code_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run)
        else $error("key code beat does not follow marker");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last_of_run))
        else $error("result beat changed while stalled");

endmodule

bind scancode_to_char_translator sctc_checker u_sctc_checker (.*);

// ===== tb/scancode_to_char_translator_tb.sv =====
// Self-checking bench for the set-1 scan code to character translator.
module scancode_to_char_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] SC_LSHIFT     = 8'd42;
    localparam logic [7:0] SC_RSHIFT     = 8'd54;
    localparam logic [7:0] SC_LSHIFT_BRK = 8'd170;
    localparam logic [7:0] SC_RSHIFT_BRK = 8'd182;
    localparam logic [7:0] SC_CAPS       = 8'd58;
    localparam logic [7:0] SC_ALT        = 8'd56;
    localparam logic [7:0] SC_ALT_BRK    = 8'd184;
    localparam logic [7:0] SC_BREAK_BIT  = 8'h80;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 27;

    localparam logic [7:0] CHAR_ROM_HEAD [60] = '{
        8'd0,   8'd27,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,  8'd54,
        8'd55,  8'd56,  8'd57,  8'd48,  8'd39,  8'd0,   8'd8,   8'd9,
        8'd113, 8'd119, 8'd101, 8'd114, 8'd116, 8'd121, 8'd117, 8'd105,
        8'd111, 8'd112, 8'd0,   8'd0,   8'd10,  8'd0,   8'd97,  8'd115,
        8'd100, 8'd102, 8'd103, 8'd104, 8'd106, 8'd107, 8'd108, 8'd164,
        8'd48,  8'd48,  8'd48,  8'd48,  8'd122, 8'd120, 8'd99,  8'd118,
        8'd98,  8'd110, 8'd109, 8'd109, 8'd109, 8'd109, 8'd109, 8'd109,
        8'd109, 8'd32,  8'd0,   8'd109
    };

    localparam logic [7:0] EXT_KEYS [14] = '{
        8'd82, 8'd83, 8'd29, 8'd157, 8'd72, 8'd80, 8'd75,
        8'd77, 8'd71, 8'd79, 8'd73, 8'd81, 8'd56, 8'd184
    };

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_of_run;
    } char_beat_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_scan_code   = 8'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_out_char;
    logic       m_last_of_run;

    char_beat_t expected_chars[$];

    logic shift_held   = 1'b0;
    logic caps_locked  = 1'b0;
    logic altgr_held   = 1'b0;
    logic ext_pending  = 1'b0;

    int  error_count   = 0;
    int  stall_cycles  = 0;
    int  typed_items   = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    bit  steady_flow   = 1'b0;

    scancode_to_char_translator uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_scan_code  (s_scan_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_last_of_run(m_last_of_run)
    );

    always #6 aclk = ~aclk;

    function automatic void push_char(input logic [7:0] ch);
        expected_chars.push_back('{out_char: ch, last_of_run: 1'b1});
    endfunction

    function automatic void push_special(input logic [7:0] code);
        expected_chars.push_back('{out_char: sctc_pkg::MARKER, last_of_run: 1'b0});
        expected_chars.push_back('{out_char: code, last_of_run: 1'b1});
    endfunction

    function automatic logic [7:0] case_char(input logic [7:0] plain, input logic [7:0] upper);
        return (shift_held || caps_locked) ? upper : plain;
    endfunction

    function automatic logic [7:0] altgr_char(input logic [7:0] plain, input logic [7:0] upper,
                                              input logic [7:0] alt);
        return altgr_held ? alt : case_char(plain, upper);
    endfunction

    function automatic void predict_chars(input logic [7:0] c);
        logic [7:0] ch;
        if (c == sctc_pkg::NULL_CODE) return;
        if (ext_pending) begin
            ext_pending = 1'b0;
            case (c)
                8'd82:      push_special(8'd15);
                8'd83:      push_char(8'd127);
                8'd29:      push_special(8'd24);
                8'd157:     push_special(8'd25);
                SC_ALT:     altgr_held = 1'b1;
                SC_ALT_BRK: altgr_held = 1'b0;
                8'd72:      push_special(8'd20);
                8'd80:      push_special(8'd21);
                8'd75:      push_special(8'd23);
                8'd77:      push_special(8'd22);
                8'd71:      push_special(8'd30);
                8'd79:      push_special(8'd31);
                8'd73:      push_special(8'd32);
                8'd81:      push_special(8'd33);
                default: ;
            endcase
            return;
        end
        if (c == sctc_pkg::PREFIX_CODE) begin
            ext_pending = 1'b1;
            return;
        end
        if (c >= sctc_pkg::FKEY_FIRST && c <= sctc_pkg::FKEY_LAST) begin
            push_special(c - sctc_pkg::FKEY_BIAS);
            return;
        end
        case (c)
            8'd1:   push_char(8'd1);
            8'd87:  push_special(8'd12);
            8'd88:  push_special(8'd13);
            8'd14:  push_char(8'd8);
            8'd15:  push_char(8'd9);
            8'd28:  push_char(8'd10);
            8'd29:  push_special(8'd24);
            8'd157: push_special(8'd25);
            SC_ALT:     push_special(8'd26);
            SC_ALT_BRK: push_special(8'd27);
            SC_LSHIFT, SC_RSHIFT:         shift_held = 1'b1;
            SC_LSHIFT_BRK, SC_RSHIFT_BRK: shift_held = 1'b0;
            SC_CAPS: caps_locked = ~caps_locked;
            8'd39:  push_char(case_char(8'd164, 8'd165));
            8'd16:  push_char(altgr_char(8'd113, 8'd81, 8'd64));
            8'd86:  push_char(case_char(8'd60, 8'd62));
            8'd53:  push_char(case_char(8'd45, 8'd95));
            8'd52:  push_char(case_char(8'd46, 8'd58));
            8'd51:  push_char(case_char(8'd44, 8'd59));
            8'd40:  push_char(altgr_char(8'd123, 8'd91, 8'd94));
            8'd43:  push_char(altgr_char(8'd125, 8'd93, 8'd96));
            8'd27:  push_char(altgr_char(8'd43, 8'd42, 8'd126));
            8'd26:  push_char(case_char(8'd239, 8'd249));
            8'd41:  push_char(altgr_char(8'd124, 8'd167, 8'd170));
            8'd13:  push_char(case_char(8'd168, 8'd173));
            8'd12:  push_char(altgr_char(8'd39, 8'd63, 8'd92));
            8'd2:   push_char(case_char(8'd49, 8'd33));
            8'd3:   push_char(case_char(8'd50, 8'd34));
            8'd4:   push_char(case_char(8'd51, 8'd35));
            8'd5:   push_char(case_char(8'd52, 8'd36));
            8'd6:   push_char(case_char(8'd53, 8'd37));
            8'd7:   push_char(case_char(8'd54, 8'd38));
            8'd8:   push_char(case_char(8'd55, 8'd47));
            8'd9:   push_char(case_char(8'd56, 8'd40));
            8'd10:  push_char(case_char(8'd57, 8'd41));
            8'd11:  push_char(case_char(8'd48, 8'd61));
            default: begin
                if (c < 8'd128) begin
                    ch = (int'(c) < 60 && int'(c) < sctc_pkg::KEY_TABLE_DEPTH) ?
                         CHAR_ROM_HEAD[c] : 8'd0;
                    if (ch >= 8'd97 && ch <= 8'd122 && (shift_held || caps_locked))
                        ch = ch - sctc_pkg::CASE_OFFSET;
                    push_char(ch);
                end
            end
        endcase
    endfunction

    task automatic send_scan_code(input logic [7:0] code);
        forever begin
            @(negedge aclk);
            if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
                s_valid     <= 1'b0;
                s_scan_code <= 8'($urandom);
            end else begin
                break;
            end
        end
        s_valid     <= 1'b1;
        s_scan_code <= code;
        do @(posedge aclk); while (!s_ready);
        typed_items++;
        predict_chars(code);
    endtask

    task automatic type_random_key();
        int         roll;
        logic [7:0] code;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            case ($urandom_range(0, 5))
                0: send_scan_code(SC_LSHIFT);
                1: send_scan_code(SC_RSHIFT);
                2: send_scan_code(SC_LSHIFT_BRK);
                3: send_scan_code(SC_RSHIFT_BRK);
                4: send_scan_code(SC_CAPS);
                default: begin
                    send_scan_code(sctc_pkg::PREFIX_CODE);
                    send_scan_code($urandom_range(0, 1) ? SC_ALT : SC_ALT_BRK);
                end
            endcase
        end else if (roll < 62) begin
            code = 8'($urandom_range(1, 88));
            if ($urandom_range(0, 3) == 0) code = code | SC_BREAK_BIT;
            send_scan_code(code);
        end else if (roll < 80) begin
            send_scan_code(sctc_pkg::PREFIX_CODE);
            send_scan_code(EXT_KEYS[$urandom_range(0, 13)]);
        end else begin
            send_scan_code(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_field_extremes();
        send_scan_code(sctc_pkg::NULL_CODE);
        send_scan_code(8'd255);
        send_scan_code(8'd127);
        send_scan_code(sctc_pkg::FKEY_FIRST);
        send_scan_code(sctc_pkg::FKEY_LAST);
    endtask

    task automatic test_extended_keys();
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(8'd72);
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(8'd83);
        // second prefix consumes the pending one and gives nothing
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(8'd30);
        // zero byte leaves the prefix pending
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(sctc_pkg::NULL_CODE);
        send_scan_code(8'd82);
    endtask

    task automatic test_modifier_keys();
        send_scan_code(SC_LSHIFT);
        send_scan_code(8'd30);
        send_scan_code(SC_LSHIFT_BRK);
        send_scan_code(SC_CAPS);
        send_scan_code(8'd39);
        send_scan_code(SC_CAPS);
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(SC_ALT);
        send_scan_code(8'd16);
        send_scan_code(sctc_pkg::PREFIX_CODE);
        send_scan_code(SC_ALT_BRK);
        send_scan_code(8'd16);
    endtask

    task automatic test_random_typing(input int target);
        int start;
        start = typed_items;
        while (typed_items - start < target) type_random_key();
    endtask

    task automatic test_output_backpressure();
        hold_requests++;
        repeat (40) send_scan_code(8'($urandom_range(sctc_pkg::FKEY_FIRST, sctc_pkg::FKEY_LAST)));
    endtask

    task automatic test_steady_flow();
        steady_flow = 1'b1;
        repeat (120) type_random_key();
        steady_flow = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady_flow) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        char_beat_t exp_beat;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected beat: out_char %0d last_of_run %0b", m_out_char, m_last_of_run);
                error_count++;
            end else begin
                exp_beat = expected_chars.pop_front();
                if (m_out_char !== exp_beat.out_char) begin
                    $error("out_char: expected %0d, got %0d", exp_beat.out_char, m_out_char);
                    error_count++;
                end
                if (m_last_of_run !== exp_beat.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b",
                           exp_beat.last_of_run, m_last_of_run);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("scancode_to_char_translator test failed");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_extended_keys();
        test_modifier_keys();
        test_random_typing(280);
        test_output_backpressure();
        test_random_typing(280);
        test_steady_flow();
        test_random_typing(50);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("scancode_to_char_translator test passed");
        end else begin
            $display("scancode_to_char_translator test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sctc_pkg.sv
rtl/sctc_front.sv
rtl/sctc_queue.sv
rtl/sctc_back.sv
rtl/scancode_to_char_translator.sv
rtl/sctc_checker.sv
tb/scancode_to_char_translator_tb.sv
